[hw/rtl/ctr_pkg.sv]
// Shared types, constants and codes of the CAN command and text reassembly block.
package ctr_pkg;

	localparam int TextBytes  = 256;
	localparam int Banks      = 8;
	localparam int BankRows   = TextBytes / Banks;
	localparam int RowW       = $clog2(BankRows);
	localparam int LaneW      = $clog2(Banks);
	localparam int PosW       = $clog2(TextBytes);
	localparam int QueueDepth = 4;
	localparam int QPtrW      = $clog2(QueueDepth);

	localparam logic [7:0] CMD_FIRST = 8'h83;
	localparam logic [7:0] CMD_LAST  = 8'h8A;
	localparam logic [7:0] CMD_TEXT  = 8'h84;

	localparam logic [3:0] START_CHARS = 4'd4;
	localparam logic [3:0] CONT_CHARS  = 4'd8;

	localparam logic [2:0] ST_UNKNOWN = 3'd0;
	localparam logic [2:0] ST_OTHER   = 3'd1;
	localparam logic [2:0] ST_PARTIAL = 3'd2;
	localparam logic [2:0] ST_IGNORED = 3'd3;
	localparam logic [2:0] ST_CHUNK   = 3'd4;

	localparam logic [2:0] TEXT_INDEX = 3'd1;

	typedef struct packed {
		logic [2:0]  status;
		logic [2:0]  index;
		logic [15:0] obj_num;
		logic [7:0]  length;
		logic [63:0] data;
	} entry_t;

	typedef struct packed {
		logic [Banks-1:0]           en;
		logic [Banks-1:0][RowW-1:0] row;
		logic [Banks-1:0][7:0]      data;
	} store_wr_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_EMIT
	} back_state_t;

endpackage

[hw/rtl/ctr_if.sv]
// Valid/ready channel interfaces for CAN frames and for result beats.
interface ctr_frame_if;
	logic        valid;
	logic        ready;
	logic [10:0] frame_id;
	logic [3:0]  frame_len;
	logic [63:0] frame_data;

	modport source(output valid, output frame_id, output frame_len, output frame_data,
		input ready);
	modport sink(input valid, input frame_id, input frame_len, input frame_data,
		output ready);
endinterface

interface ctr_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [2:0]  command_index;
	logic [15:0] object_number;
	logic [7:0]  text_length;
	logic [7:0]  chunk_offset;
	logic [63:0] payload_bytes;
	logic        last;

	modport source(output valid, output status, output command_index, output object_number,
		output text_length, output chunk_offset, output payload_bytes, output last,
		input ready);
	modport sink(input valid, input status, input command_index, input object_number,
		input text_length, input chunk_offset, input payload_bytes, input last,
		output ready);
endinterface

[hw/rtl/ctr_front.sv]
// Front end: registers a frame, classifies it, tracks text collection and writes text bytes.
module ctr_front (
	input  logic               clk,
	input  logic               arst_n,
	ctr_frame_if.sink          frame,
	output logic               push,
	output ctr_pkg::entry_t    push_entry,
	input  logic               q_full,
	input  logic               chunks_done,
	output ctr_pkg::store_wr_t store_wr
);
	import ctr_pkg::*;

	logic        valid_s1;
	logic [10:0] id_s1;
	logic [3:0]  len_s1;
	logic [63:0] data_s1;

	logic [7:0]  exp_q;
	logic [7:0]  rem_q;
	logic [15:0] obj_q;
	logic        pending_q;

	logic [7:0]  cmd;
	logic [7:0]  idx_full;
	logic        known;
	logic        is_text;
	logic        text_data;
	logic        start;
	logic        writes;
	logic        proc;
	logic [7:0]  rem_in;
	logic [7:0]  exp_in;
	logic [3:0]  cap;
	logic [3:0]  fill;
	logic [7:0]  off;
	logic [7:0]  rem_next;
	logic [63:0] src;
	logic [Banks-1:0][7:0] src_b;
	logic [LaneW-1:0] lane_sel [Banks];
	logic [PosW-1:0]  lane_pos [Banks];
	entry_t      entry;

	assign cmd       = id_s1[10:3];
	assign idx_full  = cmd - CMD_FIRST;
	assign known     = (cmd >= CMD_FIRST) && (cmd <= CMD_LAST);
	assign is_text   = (cmd == CMD_TEXT);
	assign text_data = is_text && (len_s1 != 4'd0);
	assign start     = (data_s1[7:0] == 8'd0);
	assign writes    = text_data && (start || (exp_q != 8'd0));

	// Text frames with data wait while a finished message is queued or still being read out of the store.
	assign proc        = valid_s1 && !q_full && !(text_data && pending_q);
	assign frame.ready = !valid_s1 || proc;

	always_comb begin
		rem_in   = start ? data_s1[15:8] : rem_q;
		exp_in   = start ? data_s1[15:8] : exp_q;
		cap      = start ? START_CHARS : CONT_CHARS;
		fill     = (rem_in > {4'd0, cap}) ? cap : rem_in[3:0];
		off      = start ? 8'd0 : (exp_q - rem_q);
		src      = start ? {32'd0, data_s1[63:32]} : data_s1;
		rem_next = rem_in - {4'd0, fill};
	end

	assign src_b = src;

	always_comb begin
		entry = '{status: ST_UNKNOWN, index: 3'd0, obj_num: 16'd0, length: 8'd0, data: 64'd0};
		if (known && !is_text) begin
			entry.status = ST_OTHER;
			entry.index  = idx_full[2:0];
			entry.data   = data_s1;
		end else if (is_text) begin
			entry.index = TEXT_INDEX;
			if (!writes || exp_in == 8'd0) begin
				entry.status = ST_IGNORED;
			end else if (rem_next != 8'd0) begin
				entry.status = ST_PARTIAL;
			end else begin
				entry.status  = ST_CHUNK;
				entry.obj_num = start ? data_s1[31:16] : obj_q;
				entry.length  = exp_in;
			end
		end
	end

	assign push       = proc;
	assign push_entry = entry;

	// Each text byte lands in the bank given by the low bits of its position.
	always_comb begin
		for (int b = 0; b < Banks; b++) begin
			lane_sel[b]         = LaneW'(b) - off[LaneW-1:0];
			lane_pos[b]         = off + PosW'(lane_sel[b]);
			store_wr.en[b]      = proc && writes && ({1'b0, lane_sel[b]} < fill);
			store_wr.row[b]     = lane_pos[b][PosW-1:LaneW];
			store_wr.data[b]    = src_b[lane_sel[b]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame.ready) begin
			valid_s1 <= frame.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.ready && frame.valid) begin
			id_s1   <= frame.frame_id;
			len_s1  <= frame.frame_len;
			data_s1 <= frame.frame_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q     <= 8'd0;
			rem_q     <= 8'd0;
			obj_q     <= 16'd0;
			pending_q <= 1'b0;
		end else begin
			if (proc && writes) begin
				rem_q <= rem_next;
				exp_q <= (rem_next == 8'd0) ? 8'd0 : exp_in;
				if (start) begin
					obj_q <= data_s1[31:16];
				end
			end
			if (proc && entry.status == ST_CHUNK) begin
				pending_q <= 1'b1;
			end else if (chunks_done) begin
				pending_q <= 1'b0;
			end
		end
	end

endmodule

[hw/rtl/ctr_queue.sv]
// Short queue of classified frames between the front end and the result sequencer.
module ctr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ctr_pkg::entry_t push_entry,
	output logic            full,
	output logic            pop_valid,
	output ctr_pkg::entry_t pop_entry,
	input  logic            pop
);
	import ctr_pkg::*;

	entry_t           slot_q [QueueDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QPtrW:0]   count_q;

	assign full      = (count_q == (QPtrW+1)'(QueueDepth));
	assign pop_valid = (count_q != '0);
	assign pop_entry = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hw/rtl/ctr_back.sv]
// Back end: text store banks, chunk read-out sequencer and the result output register.
module ctr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  ctr_pkg::entry_t    q_entry,
	output logic               q_pop,
	output logic               chunks_done,
	input  ctr_pkg::store_wr_t store_wr,
	ctr_result_if.source       result
);
	import ctr_pkg::*;

	back_state_t state_q;
	back_state_t state_d;
	entry_t      cur_q;
	logic [RowW-1:0] k_q;
	logic [RowW-1:0] last_k;
	logic [7:0]  len_m1;
	logic        can_load;
	logic        rd_en;
	logic        load_direct;
	logic        load_chunk;
	logic [Banks-1:0][7:0] rd_data_q;
	logic [Banks-1:0][7:0] masked;

	logic        out_valid_q;
	logic [2:0]  out_status_q;
	logic [2:0]  out_index_q;
	logic [15:0] out_obj_q;
	logic [7:0]  out_len_q;
	logic [7:0]  out_off_q;
	logic [63:0] out_pay_q;
	logic        out_last_q;

	assign len_m1   = cur_q.length - 8'd1;
	assign last_k   = len_m1[PosW-1:LaneW];
	assign can_load = !out_valid_q || result.ready;

	// One bank per byte lane; a chunk is one row across all banks.
	for (genvar b = 0; b < Banks; b++) begin : g_bank
		logic [7:0] mem [BankRows];

		always_ff @(posedge clk) begin
			if (store_wr.en[b]) begin
				mem[store_wr.row[b]] <= store_wr.data[b];
			end
		end

		always_ff @(posedge clk) begin
			if (rd_en) begin
				rd_data_q[b] <= mem[k_q];
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (q_valid && can_load && q_entry.status == ST_CHUNK) begin
					state_d = BK_READ;
				end
			end
			BK_READ: begin
				state_d = BK_EMIT;
			end
			BK_EMIT: begin
				if (can_load) begin
					state_d = (k_q == last_k) ? BK_IDLE : BK_READ;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_comb begin
		q_pop       = 1'b0;
		rd_en       = 1'b0;
		load_direct = 1'b0;
		load_chunk  = 1'b0;
		chunks_done = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				q_pop       = q_valid && can_load;
				load_direct = q_valid && can_load && (q_entry.status != ST_CHUNK);
			end
			BK_READ: begin
				rd_en       = 1'b1;
				chunks_done = (k_q == last_k);
			end
			BK_EMIT: begin
				load_chunk = can_load;
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	// Bytes at or past the text length go out as zero.
	always_comb begin
		for (int i = 0; i < Banks; i++) begin
			masked[i] = ({k_q, LaneW'(i)} < cur_q.length) ? rd_data_q[i] : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_direct || load_chunk) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_entry;
			k_q   <= '0;
		end else if (load_chunk) begin
			k_q <= k_q + 1'b1;
		end
		if (load_direct) begin
			out_status_q <= q_entry.status;
			out_index_q  <= q_entry.index;
			out_obj_q    <= 16'd0;
			out_len_q    <= 8'd0;
			out_off_q    <= 8'd0;
			out_pay_q    <= q_entry.data;
			out_last_q   <= 1'b1;
		end else if (load_chunk) begin
			out_status_q <= ST_CHUNK;
			out_index_q  <= cur_q.index;
			out_obj_q    <= cur_q.obj_num;
			out_len_q    <= cur_q.length;
			out_off_q    <= {k_q, {LaneW{1'b0}}};
			out_pay_q    <= masked;
			out_last_q   <= (k_q == last_k);
		end
	end

	assign result.valid         = out_valid_q;
	assign result.status        = out_status_q;
	assign result.command_index = out_index_q;
	assign result.object_number = out_obj_q;
	assign result.text_length   = out_len_q;
	assign result.chunk_offset  = out_off_q;
	assign result.payload_bytes = out_pay_q;
	assign result.last          = out_last_q;

endmodule

[hw/rtl/can_command_text_reassembler_core.sv]
// Top level of the CAN command dispatcher with text message reassembly.
// A frame is registered when it is accepted and then enters the four-entry queue. A frame
// that gives one result is loaded from the queue into the output register, which offers
// its beat. A frame that completes a text message of length L gives ceil(L/8) chunk beats.
// The entry is first taken from the queue; each chunk then reads a row of the eight
// byte-lane banks of the text store and is loaded into the output register. From the time
// that frame is queued until its last row is read, frames that carry text wait at the
// input; other frames keep flowing into the queue. The text store has no reset and no
// clearing pass, since a message always writes every byte that it later sends.
module can_command_text_reassembler_core (
	input  logic         clk,
	input  logic         arst_n,
	ctr_frame_if.sink    frame,
	ctr_result_if.source result
);
	import ctr_pkg::*;

	logic      push;
	entry_t    push_entry;
	logic      q_full;
	logic      q_valid;
	entry_t    q_entry;
	logic      q_pop;
	logic      chunks_done;
	store_wr_t store_wr;

	ctr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame       (frame),
		.push        (push),
		.push_entry  (push_entry),
		.q_full      (q_full),
		.chunks_done (chunks_done),
		.store_wr    (store_wr)
	);

	ctr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop_valid  (q_valid),
		.pop_entry  (q_entry),
		.pop        (q_pop)
	);

	ctr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_entry     (q_entry),
		.q_pop       (q_pop),
		.chunks_done (chunks_done),
		.store_wr    (store_wr),
		.result      (result)
	);

endmodule

[hw/rtl/ctr_checker.sv]
// Port-level assertions on the result channel, bound to the top level.
module ctr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [2:0]  status,
	input logic [2:0]  command_index,
	input logic [7:0]  text_length,
	input logic [7:0]  chunk_offset,
	input logic [63:0] payload_bytes,
	input logic        last
);
	import ctr_pkg::*;

	// A stalled beat keeps its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(payload_bytes) && $stable(status)
			&& $stable(last))
		else $error("result beat changed while stalled");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status != ST_CHUNK |-> last)
		else $error("non-chunk result without last");

	a_chunk_pos: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_CHUNK |->
			text_length != 8'd0 && chunk_offset[2:0] == 3'd0 && chunk_offset < text_length)
		else $error("chunk offset outside text");

	a_unknown_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_UNKNOWN |-> command_index == 3'd0 && payload_bytes == 64'd0)
		else $error("unknown command result carries data");

endmodule

bind can_command_text_reassembler_core ctr_checker u_ctr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (result.valid),
	.res_ready     (result.ready),
	.status        (result.status),
	.command_index (result.command_index),
	.text_length   (result.text_length),
	.chunk_offset  (result.chunk_offset),
	.payload_bytes (result.payload_bytes),
	.last          (result.last)
);
